### design/spq_pkg.sv
package spq_pkg;

   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int PRIO_WIDTH  = 16;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_PEEK   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [31:0]        item_value;
      logic signed [15:0] item_priority;
   } req_type;

   typedef struct packed {
      logic [31:0] out_value;
      logic [1:0]  status;
      logic        queue_empty;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic                         occupied;
      logic [VALUE_WIDTH-1:0]       value;
      logic signed [PRIO_WIDTH-1:0] prio;
   } slot_type;

   typedef struct packed {
      logic                         insert;
      logic                         remove;
      logic [VALUE_WIDTH-1:0]       value;
      logic signed [PRIO_WIDTH-1:0] prio;
   } cell_cmd_type;

endpackage

### design/sorted_priority_queue.sv
// Sorted priority queue of CAPACITY entries held in a chain of cells, highest
// priority at the head. Every cell compares its own priority with the new item
// in parallel and shifts one place toward the tail on insert or toward the head
// on remove, so one transfer is accepted per cycle while the result register
// drains. Equal priorities leave in arrival order. Insert into a full queue is
// dropped with status FULL; remove or peek on an empty queue reports status
// EMPTY. The result is registered and appears in the cycle after acceptance.
module sorted_priority_queue import spq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   slot_type   slot_w   [CAPACITY];
   logic       behind_w [CAPACITY];
   slot_type   new_slot;
   cell_cmd_type cmd;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic accept;
   logic full;
   logic empty;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = slot_w[CAPACITY-1].occupied;
   assign empty     = !slot_w[0].occupied;

   always_comb begin
      cmd.insert = accept && (req_data.mode == MODE_INSERT) && !full;
      cmd.remove = accept && (req_data.mode == MODE_REMOVE) && !empty;
      cmd.value  = VALUE_WIDTH'(req_data.item_value);
      cmd.prio   = req_data.item_priority;
      new_slot.occupied = 1'b1;
      new_slot.value    = cmd.value;
      new_slot.prio     = cmd.prio;
   end

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         if (i == 0) begin : g_head
            spq_cell u_cell (
               .clock       (clock),
               .reset       (reset),
               .cmd         (cmd),
               .prev_slot   (new_slot),
               .prev_behind (1'b1),
               .next_slot   (slot_w[1]),
               .slot        (slot_w[0]),
               .behind      (behind_w[0])
            );
         end else if (i == CAPACITY - 1) begin : g_tail
            spq_cell u_cell (
               .clock       (clock),
               .reset       (reset),
               .cmd         (cmd),
               .prev_slot   (slot_w[i-1]),
               .prev_behind (behind_w[i-1]),
               .next_slot   ('0),
               .slot        (slot_w[i]),
               .behind      (behind_w[i])
            );
         end else begin : g_mid
            spq_cell u_cell (
               .clock       (clock),
               .reset       (reset),
               .cmd         (cmd),
               .prev_slot   (slot_w[i-1]),
               .prev_behind (behind_w[i-1]),
               .next_slot   (slot_w[i+1]),
               .slot        (slot_w[i]),
               .behind      (behind_w[i])
            );
         end
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      rsp_in.out_value = '0;
      rsp_in.status    = STATUS_OK;
      unique case (req_data.mode) inside
         MODE_INSERT: begin
            if (full) begin
               rsp_in.status = STATUS_FULL;
            end
         end
         MODE_REMOVE, MODE_PEEK: begin
            if (empty) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               rsp_in.out_value = 32'(slot_w[0].value);
            end
         end
         default: ;
      endcase
      rsp_in.queue_empty = (count_in == '0);
      rsp_in.entry_count = 5'(count_in);
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/spq_cell.sv
module spq_cell import spq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  slot_type     prev_slot,
   input  logic         prev_behind,
   input  slot_type     next_slot,
   output slot_type     slot,
   output logic         behind
);

   slot_type slot_ff;
   slot_type slot_in;

   // entry stays ahead of a new item of lower or equal priority
   assign behind = slot_ff.occupied && (slot_ff.prio >= cmd.prio);
   assign slot   = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (cmd.insert) begin
         if (!behind) begin
            if (prev_behind) begin
               slot_in.occupied = 1'b1;
               slot_in.value    = cmd.value;
               slot_in.prio     = cmd.prio;
            end else begin
               slot_in = prev_slot;
            end
         end
      end else if (cmd.remove) begin
         slot_in = next_slot;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         slot_ff.occupied <= 1'b0;
      end
   end

endmodule

### design/spq_checker.sv
module spq_checker import spq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic req_transfer;
   assign req_transfer = req_valid && !req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.queue_empty == (rsp_data.entry_count == 5'd0)))
      else $error("empty flag disagrees with count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL) |->
         (rsp_data.entry_count == 5'(CAPACITY)))
      else $error("full status with queue not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_EMPTY) |->
         rsp_data.queue_empty && (rsp_data.out_value == 32'd0))
      else $error("empty status with entries present");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_transfer |=> rsp_valid)
      else $error("no result after request transfer");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

### verif/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam logic [1:0] MODE_NOP = 2'd3;
   localparam int RANDOM_OPS = 1250;
   localparam int HOLD_CYCLES = 200;

   typedef struct {
      logic [1:0]         mode;
      logic [31:0]        value;
      logic signed [15:0] prio;
      int                 reps;
      bit                 pinned;
      rsp_type            want;
   } directed_op_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // pinned expectation travels with the request it belongs to
   bit      cur_pinned = 1'b0;
   rsp_type cur_pinned_rsp = '0;

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_rsp = 1'b0;
   int mismatches = 0;

   // shadow of the sorted queue, slot 0 holds the highest priority
   logic [31:0]        model_value [CAPACITY];
   logic signed [15:0] model_prio [CAPACITY];
   int                 model_count = 0;
   rsp_type            expected_rsps [$];

   // directed ops, value increments per repetition
   directed_op_type directed_ops [15] = '{
      '{MODE_REMOVE, 32'h0, 16'sh0000, 1, 1'b1, '{32'h0, STATUS_EMPTY, 1'b1, 5'd0}},
      '{MODE_PEEK, 32'h0, 16'sh0000, 1, 1'b1, '{32'h0, STATUS_EMPTY, 1'b1, 5'd0}},
      '{MODE_NOP, 32'hFFFF_FFFF, 16'sh7FFF, 1, 1'b1, '{32'h0, STATUS_OK, 1'b1, 5'd0}},
      '{MODE_INSERT, 32'hFFFF_FFFF, 16'sh7FFF, 1, 1'b1, '{32'h0, STATUS_OK, 1'b0, 5'd1}},
      '{MODE_INSERT, 32'h0, 16'sh8000, 1, 1'b1, '{32'h0, STATUS_OK, 1'b0, 5'd2}},
      '{MODE_INSERT, 32'h2, 16'sh7FFF, 1, 1'b0, '{32'h0, STATUS_OK, 1'b0, 5'd0}},
      '{MODE_INSERT, 32'h3, 16'sh0000, 1, 1'b0, '{32'h0, STATUS_OK, 1'b0, 5'd0}},
      '{MODE_NOP, 32'hFFFF_FFFF, 16'shFFFF, 1, 1'b0, '{32'h0, STATUS_OK, 1'b0, 5'd0}},
      '{MODE_PEEK, 32'h0, 16'sh0000, 1, 1'b1,
        '{32'hFFFF_FFFF, STATUS_OK, 1'b0, 5'd4}},
      '{MODE_REMOVE, 32'h0, 16'sh0000, 1, 1'b1,
        '{32'hFFFF_FFFF, STATUS_OK, 1'b0, 5'd3}},
      '{MODE_REMOVE, 32'h0, 16'sh0000, 3, 1'b0, '{32'h0, STATUS_OK, 1'b0, 5'd0}},
      '{MODE_REMOVE, 32'h0, 16'sh0000, 1, 1'b1, '{32'h0, STATUS_EMPTY, 1'b1, 5'd0}},
      '{MODE_INSERT, 32'h100, 16'shFFFF, 16, 1'b0, '{32'h0, STATUS_OK, 1'b0, 5'd0}},
      '{MODE_INSERT, 32'hDEAD_BEEF, 16'sh7FFF, 1, 1'b1,
        '{32'h0, STATUS_FULL, 1'b0, 5'd16}},
      '{MODE_PEEK, 32'h0, 16'sh0000, 1, 1'b0, '{32'h0, STATUS_OK, 1'b0, 5'd0}}
   };

   sorted_priority_queue u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type predict_queue_op(input req_type op);
      rsp_type            res;
      logic signed [15:0] prio;
      int                 pos;
      int                 i;
      res = '0;
      prio = op.item_priority;
      case (op.mode) inside
         MODE_INSERT: begin
            if (model_count >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < model_count && model_prio[pos] >= prio) pos++;
               for (i = model_count; i > pos; i--) begin
                  model_value[i] = model_value[i-1];
                  model_prio[i] = model_prio[i-1];
               end
               model_value[pos] = op.item_value;
               model_prio[pos] = prio;
               model_count++;
            end
         end
         MODE_REMOVE, MODE_PEEK: begin
            if (model_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.out_value = model_value[0];
               if (op.mode == MODE_REMOVE) begin
                  for (i = 0; i + 1 < model_count; i++) begin
                     model_value[i] = model_value[i+1];
                     model_prio[i] = model_prio[i+1];
                  end
                  model_count--;
               end
            end
         end
         default: ;
      endcase
      res.queue_empty = (model_count == 0);
      res.entry_count = 5'(model_count);
      return res;
   endfunction

   task automatic note_failure(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
   endtask

   task automatic compare_rsp(input rsp_type want, input rsp_type got);
      if (got.out_value !== want.out_value)
         note_failure($sformatf("out_value expected %h, got %h", want.out_value,
                                got.out_value));
      if (got.status !== want.status)
         note_failure($sformatf("status expected %0d, got %0d", want.status, got.status));
      if (got.queue_empty !== want.queue_empty)
         note_failure($sformatf("queue_empty expected %0d, got %0d", want.queue_empty,
                                got.queue_empty));
      if (got.entry_count !== want.entry_count)
         note_failure($sformatf("entry_count expected %0d, got %0d", want.entry_count,
                                got.entry_count));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               note_failure($sformatf("result transfer with none expected: %h", rsp_data));
            end else begin
               want = expected_rsps.pop_front();
               compare_rsp(want, rsp_data);
            end
         end
         if (req_valid && !req_stall) begin
            want = predict_queue_op(req_data);
            if (cur_pinned) want = cur_pinned_rsp;
            expected_rsps.push_back(want);
         end
      end
   end

   task automatic send_op(input req_type op, input bit pinned, input rsp_type pinned_rsp);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 9) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= op;
      cur_pinned <= pinned;
      cur_pinned_rsp <= pinned_rsp;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
   endtask

   function automatic req_type random_op(input int insert_pct, input int prio_style);
      req_type op;
      int      pick;
      int      p;
      op = '0;
      pick = $urandom_range(0, 99);
      if (pick < 4) op.mode = MODE_NOP;
      else if (pick < 18) op.mode = MODE_PEEK;
      else if (pick < 18 + (82 * insert_pct) / 100) op.mode = MODE_INSERT;
      else op.mode = MODE_REMOVE;
      op.item_value = $urandom;
      case (prio_style)
         0: p = $urandom_range(0, 65535);
         1: p = int'($urandom_range(0, 4)) - 2;
         default: begin
            case ($urandom_range(0, 3))
               0: p = -32768;
               1: p = 32767;
               2: p = 0;
               default: p = -1;
            endcase
         end
      endcase
      op.item_priority = 16'(p);
      return op;
   endfunction

   // result side: random stall per transfer, one long hold when asked
   initial begin
      int gap;
      while (reset) @(negedge clock);
      forever begin
         gap = rsp_idle_on ? $urandom_range(0, 9) : 0;
         if (hold_rsp) begin
            gap = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      req_type op;
      int      n;
      int      sent;
      int      plen;
      int      insert_pct;
      int      prio_style;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_ops[k]) begin
         for (n = 0; n < directed_ops[k].reps; n++) begin
            op.mode = directed_ops[k].mode;
            op.item_value = directed_ops[k].value + 32'(n);
            op.item_priority = directed_ops[k].prio;
            send_op(op, directed_ops[k].pinned, directed_ops[k].want);
         end
      end

      wait_drained();
      sent = 0;
      while (sent < RANDOM_OPS) begin
         plen = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: insert_pct = 80;
            1: insert_pct = 25;
            default: insert_pct = 50;
         endcase
         prio_style = $urandom_range(0, 2);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0) wait_drained();
         for (n = 0; n < plen && sent < RANDOM_OPS; n++) begin
            if (sent == 300) begin
               hold_rsp = 1'b1;
               req_idle_on = 1'b0;
            end
            send_op(random_op(insert_pct, prio_style), 1'b0, '0);
            sent++;
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
